[hw/rtl/cct_pkg.sv]
// ----------------------------------------------------------------------------
// cct_pkg: shared types and constants of the cell coverage grid tracker
// Grid geometry, item layouts, function codes and back end states.
// ----------------------------------------------------------------------------
package cct_pkg;

	// grid geometry; cell indexes are three bits wide, so at most 8 x 8
	localparam int GRID_COLUMNS = 8;
	localparam int GRID_ROWS    = 8;
	localparam int CELL_IDX_W   = 3;
	localparam int SLOT_W       = 2 * CELL_IDX_W;
	localparam int GRID_CELLS   = 1 << SLOT_W;

	localparam int DIM_W   = 10;  // cell size registers
	localparam int VIEW_W  = 14;  // viewport fields
	localparam int COORD_W = VIEW_W + 1;  // edge sums and cell corners

	// queue between front and back; depth must be a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 2'd1;

	typedef enum logic [1:0] {
		FUNC_MASK  = 2'd0,
		FUNC_SET   = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_QUERY = 2'd3
	} func_t;

	typedef struct packed {
		func_t                 func;
		logic [CELL_IDX_W-1:0] cell_x;
		logic [CELL_IDX_W-1:0] cell_y;
		logic [7:0]            mask_value;
		logic                  last_pixel;
		logic                  status_value;
		logic [VIEW_W-1:0]     view_left;
		logic [VIEW_W-1:0]     view_top;
		logic [VIEW_W-1:0]     view_width;
		logic [VIEW_W-1:0]     view_height;
	} in_item_t;

	typedef struct packed {
		logic                  found;
		logic [CELL_IDX_W-1:0] result_x;
		logic [CELL_IDX_W-1:0] result_y;
		logic                  last;
	} out_item_t;

	// classified operation as held in the queue
	typedef struct packed {
		func_t                 func;
		logic                  in_grid;
		logic [CELL_IDX_W-1:0] cell_x;
		logic [CELL_IDX_W-1:0] cell_y;
		logic                  mask_zero;
		logic                  last_pixel;
		logic                  status_value;
		logic [COORD_W-1:0]    view_left;
		logic [COORD_W-1:0]    view_top;
		logic [COORD_W-1:0]    view_right;
		logic [COORD_W-1:0]    view_bottom;
	} op_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_FLUSH
	} back_state_t;

endpackage

[hw/rtl/cct_front.sv]
// ----------------------------------------------------------------------------
// cct_front: input stage of the tracker
// Registers each input beat, classifies it and pushes it into the queue.
// ----------------------------------------------------------------------------
module cct_front import cct_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  in_item_t      in_data,
	input  queue_status_t q_status,
	output logic          push,
	output op_item_t      push_item
);

	logic     valid_s1;
	in_item_t item_s1;

	assign in_stall = valid_s1 && q_status.full;
	assign push     = valid_s1 && !q_status.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// classify: grid range, zero pixel, viewport far edges
	always_comb begin
		push_item.func         = item_s1.func;
		push_item.in_grid      = ({1'b0, item_s1.cell_x} < (CELL_IDX_W + 1)'(GRID_COLUMNS)) &&
		                         ({1'b0, item_s1.cell_y} < (CELL_IDX_W + 1)'(GRID_ROWS));
		push_item.cell_x       = item_s1.cell_x;
		push_item.cell_y       = item_s1.cell_y;
		push_item.mask_zero    = (item_s1.mask_value == 8'd0);
		push_item.last_pixel   = item_s1.last_pixel;
		push_item.status_value = item_s1.status_value;
		push_item.view_left    = {1'b0, item_s1.view_left};
		push_item.view_top     = {1'b0, item_s1.view_top};
		push_item.view_right   = {1'b0, item_s1.view_left} + {1'b0, item_s1.view_width};
		push_item.view_bottom  = {1'b0, item_s1.view_top} + {1'b0, item_s1.view_height};
	end

endmodule

[hw/rtl/cct_queue.sv]
// ----------------------------------------------------------------------------
// cct_queue: short operation queue between front and back
// Small register FIFO with a fill count.
// ----------------------------------------------------------------------------
module cct_queue import cct_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  op_item_t      push_item,
	input  logic          pop,
	output op_item_t      pop_item,
	output queue_status_t status
);

	op_item_t               entries_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;
	logic                   do_push;
	logic                   do_pop;

	assign status.full  = (count_q == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_item     = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[hw/rtl/cct_back.sv]
// ----------------------------------------------------------------------------
// cct_back: execution side of the tracker
// Holds the status grid, runs writes and reads, scans the grid for queries.
// ----------------------------------------------------------------------------
module cct_back import cct_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  queue_status_t      q_status,
	input  op_item_t           q_item,
	output logic               pop,
	input  logic [DIM_W-1:0]   cell_width,
	input  logic [DIM_W-1:0]   cell_height,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_data
);

	back_state_t           state_q;
	back_state_t           state_d;
	logic [GRID_CELLS-1:0] status_q;
	logic                  zero_seen_q;
	logic [CELL_IDX_W-1:0] col_q;
	logic [CELL_IDX_W-1:0] row_q;
	logic [COORD_W-1:0]    px_q;
	logic [COORD_W-1:0]    py_q;
	logic [COORD_W-1:0]    vl_q;
	logic [COORD_W-1:0]    vt_q;
	logic [COORD_W-1:0]    vr_q;
	logic [COORD_W-1:0]    vb_q;
	logic                  pend_valid_q;
	logic [CELL_IDX_W-1:0] pend_x_q;
	logic [CELL_IDX_W-1:0] pend_y_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic [SLOT_W-1:0]  slot_in;
	logic [SLOT_W-1:0]  scan_slot;
	logic [COORD_W-1:0] px_end;
	logic [COORD_W-1:0] py_end;
	logic               match;
	logic               last_row;
	logic               last_cell;
	logic               out_free;
	logic               advance;
	logic               emit;
	out_item_t          emit_item;
	logic               any_zero;

	assign slot_in   = {q_item.cell_x, q_item.cell_y};
	assign scan_slot = {col_q, row_q};
	assign px_end    = px_q + COORD_W'(cell_width);
	assign py_end    = py_q + COORD_W'(cell_height);
	assign match     = !status_q[scan_slot] && (px_q >= vl_q) && (px_end <= vr_q) &&
	                   (py_q >= vt_q) && (py_end <= vb_q);
	assign last_row  = (row_q == CELL_IDX_W'(GRID_ROWS - 1));
	assign last_cell = last_row && (col_q == CELL_IDX_W'(GRID_COLUMNS - 1));
	assign out_free  = !out_valid_q || !out_stall;
	assign any_zero  = zero_seen_q || q_item.mask_zero;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_status.empty && q_item.func == FUNC_QUERY) begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (advance && last_cell) begin
					state_d = BK_FLUSH;
				end
			end
			BK_FLUSH: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		advance   = 1'b0;
		emit      = 1'b0;
		emit_item = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_status.empty) begin
					unique case (q_item.func)
						FUNC_MASK, FUNC_SET, FUNC_QUERY: begin
							pop = 1'b1;
						end
						FUNC_READ: begin
							pop                = out_free;
							emit               = out_free;
							emit_item.found    = q_item.in_grid && status_q[slot_in];
							emit_item.result_x = q_item.cell_x;
							emit_item.result_y = q_item.cell_y;
							emit_item.last     = 1'b1;
						end
						default: pop = 1'b0;
					endcase
				end
			end
			BK_SCAN: begin
				// a new match releases the one held back, which is then not last
				advance            = !(match && pend_valid_q) || out_free;
				emit               = match && pend_valid_q && out_free;
				emit_item.found    = 1'b1;
				emit_item.result_x = pend_x_q;
				emit_item.result_y = pend_y_q;
				emit_item.last     = 1'b0;
			end
			BK_FLUSH: begin
				emit               = out_free;
				emit_item.found    = pend_valid_q;
				emit_item.result_x = pend_valid_q ? pend_x_q : '0;
				emit_item.result_y = pend_valid_q ? pend_y_q : '0;
				emit_item.last     = 1'b1;
			end
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			status_q     <= '0;
			zero_seen_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == BK_IDLE && pop) begin
				case (q_item.func)
					FUNC_MASK: begin
						if (q_item.last_pixel) begin
							if (q_item.in_grid) begin
								status_q[slot_in] <= !any_zero;
							end
							zero_seen_q <= 1'b0;
						end else begin
							zero_seen_q <= any_zero;
						end
					end
					FUNC_SET: begin
						if (q_item.in_grid) begin
							status_q[slot_in] <= q_item.status_value;
						end
					end
					FUNC_QUERY: pend_valid_q <= 1'b0;
					default: pend_valid_q <= pend_valid_q;
				endcase
			end
			if (state_q == BK_SCAN && advance && match) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_item;
		end
		if (state_q == BK_IDLE && pop && q_item.func == FUNC_QUERY) begin
			vl_q  <= q_item.view_left;
			vt_q  <= q_item.view_top;
			vr_q  <= q_item.view_right;
			vb_q  <= q_item.view_bottom;
			col_q <= '0;
			row_q <= '0;
			px_q  <= '0;
			py_q  <= '0;
		end
		if (state_q == BK_SCAN && advance) begin
			if (match) begin
				pend_x_q <= col_q;
				pend_y_q <= row_q;
			end
			if (last_row) begin
				row_q <= '0;
				col_q <= col_q + 1'b1;
				py_q  <= '0;
				px_q  <= px_end;
			end else begin
				row_q <= row_q + 1'b1;
				py_q  <= py_end;
			end
		end
	end

	a_scan_holds_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCAN) |-> !pop)
		else $error("queue popped during a grid scan");

	a_empty_answer_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !emit_item.found) |-> emit_item.last)
		else $error("result without a match is not marked last");

	a_flush_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_FLUSH && emit) |=> (state_q == BK_IDLE && out_valid_q && out_q.last))
		else $error("query end did not deliver a last result");

endmodule

[hw/rtl/cell_coverage_grid_tracker.sv]
// ----------------------------------------------------------------------------
// cell_coverage_grid_tracker: grid of per-cell coverage flags
// Input beats carry mask pixels, flag writes, flag reads and viewport
// queries; each result beat names one cell and marks the final one.
//
// Channels: in_valid/in_stall with in_data, out_valid/out_stall with
// out_data, and a write-only register port cfg_valid/cfg_ready with
// cfg_index and cfg_data (0 cell width, 1 cell height). cfg_ready is
// always high; write only while no item is in flight.
// Throughput: the back end takes a mask pixel, set or read beat from the
// queue every clock, so a stream of them runs at one beat per cycle while
// the output is not stalled. A query holds the back end through a start
// step, a scan of every cell of the grid and a closing step; the scan and
// the closing step may wait while the output is stalled.
// A read answer passes the input register, the queue and the output
// register on its way to out_valid.
// Reset clears every flag, the zero-pixel tracker and both cell sizes at
// once. When the receiver stalls, the output register holds its beat, the
// back end waits, the queue fills and then in_stall rises.
// ----------------------------------------------------------------------------
module cell_coverage_grid_tracker import cct_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	logic [DIM_W-1:0] cell_width_q;
	logic [DIM_W-1:0] cell_height_q;
	queue_status_t    q_status;
	logic             push;
	op_item_t         push_item;
	logic             pop;
	op_item_t         pop_item;

	// register writes always land at once; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_q  <= '0;
			cell_height_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CELL_WIDTH:  cell_width_q  <= cfg_data;
				CFG_CELL_HEIGHT: cell_height_q <= cfg_data;
				default: cell_width_q <= cell_width_q;
			endcase
		end
	end

	// front: register and classify each beat
	cct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_status  (q_status),
		.push      (push),
		.push_item (push_item)
	);

	// queue: decouple input acceptance from grid scans and output stalls
	cct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.status    (q_status)
	);

	// back: own the flags, answer reads, scan for queries
	cct_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.q_item      (pop_item),
		.pop         (pop),
		.cell_width  (cell_width_q),
		.cell_height (cell_height_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule
